// ===== hdl/display_mode_best_select_unit_macros.svh =====
// Assertion macros for the display mode best select unit.
// Included by the top level; expects clk and arst_n in scope.
`ifndef DISPLAY_MODE_BEST_SELECT_UNIT_MACROS_SVH
`define DISPLAY_MODE_BEST_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dmbs_pkg.sv =====
// Shared types, codes and helper functions of the display mode best select unit.
// No dependencies; imported by every module of the block.
package dmbs_pkg;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int VOL_W  = 38;
	localparam int BPP_W  = 6;

	// Configuration register indexes (byte address / 4)
	localparam logic [2:0] REG_WANT_WIDTH   = 3'd0;
	localparam logic [2:0] REG_WANT_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_WANT_DEPTH   = 3'd2;
	localparam logic [2:0] REG_LIMIT_WIDTH  = 3'd3;
	localparam logic [2:0] REG_LIMIT_HEIGHT = 3'd4;

	// Descriptor kind
	localparam logic KIND_CURRENT = 1'b0;

	// Pixel formats
	localparam logic [1:0] PF_RGBA8   = 2'd0;
	localparam logic [1:0] PF_BGRA8   = 2'd1;
	localparam logic [1:0] PF_BITMASK = 2'd2;
	localparam logic [1:0] PF_BLT     = 2'd3;

	localparam logic [BPP_W-1:0] BPP_RGBA = 6'd32;

	typedef struct packed {
		logic [15:0] want_width;
		logic [15:0] want_height;
		logic [5:0]  want_depth;
		logic [11:0] limit_width;
		logic [11:0] limit_height;
	} dmbs_cfg_t;

	typedef struct packed {
		logic capture;
		logic mul1;
		logic mul2;
		logic update;
		logic emit;
	} dmbs_cmd_t;

	typedef struct packed {
		logic last;
	} dmbs_sts_t;

	// Bits per pixel of a pixel format; bitmask formats use the top set bit of
	// the channel union, or zero when two channels share a bit.
	function automatic logic [BPP_W-1:0] pixel_bpp(
		input logic [1:0]  fmt,
		input logic [31:0] r,
		input logic [31:0] g,
		input logic [31:0] b,
		input logic [31:0] a
	);
		logic [31:0]      all;
		logic             overlap;
		logic [BPP_W-1:0] top;
		all     = r | g | b | a;
		overlap = |((r & g) | (r & b) | (g & b) | (r & a) | (g & a) | (b & a));
		top     = '0;
		for (int i = 0; i < 32; i++) begin
			if (all[i]) begin
				top = BPP_W'(i + 1);
			end
		end
		case (fmt)
			PF_RGBA8, PF_BGRA8: pixel_bpp = BPP_RGBA;
			PF_BITMASK:         pixel_bpp = overlap ? '0 : top;
			default:            pixel_bpp = '0;
		endcase
	endfunction

endpackage

// ===== hdl/dmbs_cfg.sv =====
// APB-style configuration register file of the display mode best select unit.
// Depends on dmbs_pkg for register indexes and the configuration struct.
module dmbs_cfg import dmbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output dmbs_cfg_t         cfg
);

	dmbs_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_WANT_WIDTH:   cfg_q.want_width   <= pwdata[15:0];
				REG_WANT_HEIGHT:  cfg_q.want_height  <= pwdata[15:0];
				REG_WANT_DEPTH:   cfg_q.want_depth   <= pwdata[5:0];
				REG_LIMIT_WIDTH:  cfg_q.limit_width  <= pwdata[11:0];
				REG_LIMIT_HEIGHT: cfg_q.limit_height <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WANT_WIDTH:   prdata = {16'd0, cfg_q.want_width};
			REG_WANT_HEIGHT:  prdata = {16'd0, cfg_q.want_height};
			REG_WANT_DEPTH:   prdata = {26'd0, cfg_q.want_depth};
			REG_LIMIT_WIDTH:  prdata = {20'd0, cfg_q.limit_width};
			REG_LIMIT_HEIGHT: prdata = {20'd0, cfg_q.limit_height};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hdl/dmbs_ctrl.sv =====
// Sequencing controller of the display mode best select unit.
// Depends on dmbs_pkg for the command and status structs.
module dmbs_ctrl import dmbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      desc_valid,
	output logic      desc_stall,
	output logic      res_valid,
	input  logic      res_stall,
	input  dmbs_sts_t sts,
	output dmbs_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL1 = 4'b0010,
		ST_MUL2 = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free   = !res_valid_q || !res_stall;
	assign desc_stall = (state_q != ST_IDLE);
	assign res_valid  = res_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = desc_valid;
				if (desc_valid) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				// hold a closing request until the result slot is free
				if (!sts.last || out_free) begin
					cmd.update = 1'b1;
					cmd.emit   = sts.last;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/dmbs_dp.sv =====
// Datapath of the display mode best select unit: bpp decode, volume products,
// best-mode tracking and the result register. Depends on dmbs_pkg.
module dmbs_dp import dmbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dmbs_cfg_t        cfg,
	input  dmbs_cmd_t        cmd,
	output dmbs_sts_t        sts,
	input  logic             kind,
	input  logic [15:0]      mode_id,
	input  logic             query_ok,
	input  logic [15:0]      mode_width,
	input  logic [15:0]      mode_height,
	input  logic [1:0]       pix_fmt,
	input  logic [31:0]      red_mask,
	input  logic [31:0]      green_mask,
	input  logic [31:0]      blue_mask,
	input  logic [31:0]      alpha_mask,
	input  logic             last,
	output logic             found,
	output logic [15:0]      sel_mode,
	output logic             switch_needed,
	output logic [BPP_W-1:0] best_bpp
);

	// Captured request
	logic             kind_s1, ok_s1, last_s1;
	logic [15:0]      mode_s1, w_s1, h_s1;
	logic [1:0]       fmt_s1;
	logic [31:0]      r_s1, g_s1, b_s1, a_s1;
	// First product and tests
	logic [BPP_W-1:0] bpp_s2;
	logic [31:0]      wh_s2;
	logic             pass_s2, keep_s2;
	// Volume
	logic [VOL_W-1:0] vol_s3;

	// Batch state
	logic [15:0]      current_mode_q, chosen_mode_q;
	logic             have_current_q, kept_current_q, any_found_q;
	logic [VOL_W-1:0] best_volume_q;
	logic [BPP_W-1:0] chosen_bpp_q;

	logic [15:0]      current_mode_d, chosen_mode_d;
	logic             have_current_d, kept_current_d, any_found_d;
	logic [VOL_W-1:0] best_volume_d;
	logic [BPP_W-1:0] chosen_bpp_d;

	// Result register
	logic             found_q, switch_q;
	logic [15:0]      sel_mode_q;
	logic [BPP_W-1:0] best_bpp_q;

	logic [BPP_W-1:0] bpp;
	logic             size_ok, depth_ok, too_big, usable;

	assign sts.last = last_s1;

	assign bpp      = pixel_bpp(fmt_s1, r_s1, g_s1, b_s1, a_s1);
	assign size_ok  = (w_s1 == cfg.want_width && h_s1 == cfg.want_height) ||
	                  (cfg.want_width == '0 && cfg.want_height == '0);
	assign depth_ok = (bpp == cfg.want_depth) || (cfg.want_depth == '0);
	assign too_big  = (cfg.limit_width != '0) &&
	                  ((w_s1 > {4'd0, cfg.limit_width}) || (h_s1 > {4'd0, cfg.limit_height}));
	assign usable   = ok_s1 && (bpp != '0) && size_ok && depth_ok;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1 <= kind;
			mode_s1 <= mode_id;
			ok_s1   <= query_ok;
			w_s1    <= mode_width;
			h_s1    <= mode_height;
			fmt_s1  <= pix_fmt;
			r_s1    <= red_mask;
			g_s1    <= green_mask;
			b_s1    <= blue_mask;
			a_s1    <= alpha_mask;
			last_s1 <= last;
		end
		if (cmd.mul1) begin
			bpp_s2  <= bpp;
			wh_s2   <= w_s1 * h_s1;
			keep_s2 <= usable;
			pass_s2 <= usable && !too_big;
		end
		if (cmd.mul2) begin
			vol_s3 <= VOL_W'(wh_s2) * VOL_W'(bpp_s2);
		end
	end

	always_comb begin
		current_mode_d = current_mode_q;
		have_current_d = have_current_q;
		kept_current_d = kept_current_q;
		any_found_d    = any_found_q;
		best_volume_d  = best_volume_q;
		chosen_mode_d  = chosen_mode_q;
		chosen_bpp_d   = chosen_bpp_q;
		if (kind_s1 == KIND_CURRENT) begin
			current_mode_d = mode_s1;
			have_current_d = 1'b1;
			if (keep_s2) begin
				kept_current_d = 1'b1;
				any_found_d    = 1'b1;
				chosen_mode_d  = mode_s1;
				chosen_bpp_d   = bpp_s2;
			end
		end else if (!kept_current_q && pass_s2) begin
			any_found_d = 1'b1;
			if (best_volume_q < vol_s3) begin
				best_volume_d = vol_s3;
				chosen_mode_d = mode_s1;
				chosen_bpp_d  = bpp_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_mode_q <= '0;
			have_current_q <= 1'b0;
			kept_current_q <= 1'b0;
			any_found_q    <= 1'b0;
			best_volume_q  <= '0;
			chosen_mode_q  <= '0;
			chosen_bpp_q   <= '0;
		end else if (cmd.update) begin
			if (last_s1) begin
				current_mode_q <= '0;
				have_current_q <= 1'b0;
				kept_current_q <= 1'b0;
				any_found_q    <= 1'b0;
				best_volume_q  <= '0;
				chosen_mode_q  <= '0;
				chosen_bpp_q   <= '0;
			end else begin
				current_mode_q <= current_mode_d;
				have_current_q <= have_current_d;
				kept_current_q <= kept_current_d;
				any_found_q    <= any_found_d;
				best_volume_q  <= best_volume_d;
				chosen_mode_q  <= chosen_mode_d;
				chosen_bpp_q   <= chosen_bpp_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found_q    <= any_found_d;
			sel_mode_q <= any_found_d ? chosen_mode_d : '0;
			best_bpp_q <= any_found_d ? chosen_bpp_d : '0;
			switch_q   <= any_found_d &&
			              (!have_current_d || (chosen_mode_d != current_mode_d));
		end
	end

	assign found         = found_q;
	assign sel_mode      = sel_mode_q;
	assign switch_needed = switch_q;
	assign best_bpp      = best_bpp_q;

endmodule

// ===== hdl/display_mode_best_select_unit.sv =====
// Display mode best select unit: top level joining the register file,
// controller and datapath. Depends on dmbs_pkg and the assertion macro header.
//
// The block reads a batch of display mode descriptors, one request at a time,
// and answers with one result on the descriptor marked last. Each request
// passes its steps in order before the next is accepted: capture, then the
// bpp decode, the 16x16 width*height product and the match tests, then the
// product with bpp, and last the compare against the best volume and the
// update of the batch state. These serial steps through the two registered
// multipliers set the rate. A closing request also waits in its last step
// while an earlier result still sits unread in the result register. Configure
// the want and limit registers through the APB port only while no request is
// in flight; a request of zero for width and height, or for depth, matches
// anything, and a zero width limit switches the size limit off.
module display_mode_best_select_unit import dmbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	// descriptor channel
	input  logic              desc_valid,
	output logic              desc_stall,
	input  logic              kind,
	input  logic [15:0]       mode_id,
	input  logic              query_ok,
	input  logic [15:0]       mode_width,
	input  logic [15:0]       mode_height,
	input  logic [1:0]        pix_fmt,
	input  logic [31:0]       red_mask,
	input  logic [31:0]       green_mask,
	input  logic [31:0]       blue_mask,
	input  logic [31:0]       alpha_mask,
	input  logic              last,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic              found,
	output logic [15:0]       sel_mode,
	output logic              switch_needed,
	output logic [BPP_W-1:0]  best_bpp
);

	`include "display_mode_best_select_unit_macros.svh"

	dmbs_cfg_t cfg;
	dmbs_cmd_t cmd;
	dmbs_sts_t sts;

	// Register file: want size and depth, preferred size limit
	dmbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Controller: walk each request through its four steps, own both handshakes
	dmbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Datapath: decode, multiply, compare, track best, hold the result
	dmbs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.mode_id       (mode_id),
		.query_ok      (query_ok),
		.mode_width    (mode_width),
		.mode_height   (mode_height),
		.pix_fmt       (pix_fmt),
		.red_mask      (red_mask),
		.green_mask    (green_mask),
		.blue_mask     (blue_mask),
		.alpha_mask    (alpha_mask),
		.last          (last),
		.found         (found),
		.sel_mode      (sel_mode),
		.switch_needed (switch_needed),
		.best_bpp      (best_bpp)
	);

	// A new result never lands on one that is still waiting
	`DMBS_ASSERT_NOW(a_no_overwrite, cmd.emit, !res_valid || !res_stall, "result overwritten")
	// One request in flight: after acceptance the channel stalls
	`DMBS_ASSERT_NEXT(a_one_inflight, desc_valid && !desc_stall, desc_stall, "second request taken")
	// A result appears after every closing update
	`DMBS_ASSERT_NEXT(a_emit_shows, cmd.emit, res_valid, "emitted result not shown")
	// No request is taken in the cycle the batch state updates
	`DMBS_ASSERT_NOW(a_update_busy, cmd.update, desc_stall, "request taken during update")

endmodule
